[rtl/core/dtd_pkg.sv]
// shared types and constants of the task dispatcher
`default_nettype none
package dtd_pkg;

  localparam int MAX_TASKS = 64;
  localparam int MAX_SUCCESSORS = 8;
  localparam int TASK_W = $clog2(MAX_TASKS);
  localparam int SLOT_W = $clog2(MAX_SUCCESSORS);
  localparam int EDGE_W = TASK_W + SLOT_W;
  localparam int NSUCC_W = 4;
  localparam int PEND_W = 9;
  localparam int FCNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    OP_LOAD_TASK = 3'd0,
    OP_LOAD_EDGE = 3'd1,
    OP_START     = 3'd2,
    OP_TAKE      = 3'd3,
    OP_FINISH    = 3'd4
  } op_t;

  // one decoded command beat
  typedef struct packed {
    logic                  is_load_task;
    logic                  is_load_edge;
    logic                  is_start;
    logic                  is_take;
    logic                  is_finish;
    logic [TASK_W-1:0]     task_index;
    logic [SLOT_W-1:0]     edge_slot;
    logic [TASK_W-1:0]     edge_target;
    logic [NSUCC_W-1:0]    successor_count;
    logic                  main_only;
    logic                  start_dirty;
    logic [PEND_W-1:0]     start_pending;
    logic                  from_main;
  } cmd_t;

  // static task table entry
  typedef struct packed {
    logic               main_only;
    logic               start_dirty;
    logic [PEND_W-1:0]  start_pending;
    logic [NSUCC_W-1:0] succ_count;
  } task_entry_t;

endpackage
`default_nettype wire

[rtl/core/dtd_if.sv]
// request and response channel interfaces of the task dispatcher
`default_nettype none
interface dtd_req_if;
  import dtd_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [5:0]         task_index;
  logic [2:0]         edge_slot;
  logic [5:0]         edge_target;
  logic [3:0]         successor_count;
  logic               main_only;
  logic               start_dirty;
  logic [8:0]         start_pending;
  logic               from_main;
  modport source (output valid, opcode, task_index, edge_slot, edge_target, successor_count,
                  main_only, start_dirty, start_pending, from_main, input ready);
  modport sink (input valid, opcode, task_index, edge_slot, edge_target, successor_count,
                main_only, start_dirty, start_pending, from_main, output ready);
endinterface

interface dtd_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       granted_valid;
  logic [5:0] granted_task;
  logic [6:0] in_flight;
  logic       all_done;
  modport source (output valid, status, granted_valid, granted_task, in_flight, all_done,
                  input ready);
  modport sink (input valid, status, granted_valid, granted_task, in_flight, all_done,
                output ready);
endinterface
`default_nettype wire

[rtl/core/dataflow_task_dispatcher.sv]
// a finish walks its successors one at a time; a start step walks every task entry
// throughput: one item at a time; the back-end sequencer and its one-read-port rams set it
// a two-beat command queue lets the front accept while the back is busy
// result register decouples the response channel
// reset (rst, synchronous): fifos empty, in-flight zero, working flags read as zero
// task and edge tables are not cleared and hold nothing meaningful until loaded
`default_nettype none
module dataflow_task_dispatcher (
  input  wire logic clk,
  input  wire logic rst,
  dtd_req_if.sink   req,
  dtd_rsp_if.source rsp
);
  import dtd_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // front: accept and classify beats
  dtd_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  // back: execute commands
  dtd_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd), .rsp(rsp)
  );
endmodule
`default_nettype wire

[rtl/core/dtd_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module dtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/dtd_front.sv]
// front end: accepts request beats, decodes them and queues commands
`default_nettype none
module dtd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  dtd_req_if.sink            req,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output dtd_pkg::cmd_t      cmd
);
  import dtd_pkg::*;

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  cmd_t       dec;
  logic       push;
  logic       pop;

  // decode the opcode into command class flags, at most one of them set
  always_comb begin
    dec = '0;
    dec.is_load_task    = (req.opcode == OP_LOAD_TASK);
    dec.is_load_edge    = (req.opcode == OP_LOAD_EDGE);
    dec.is_start        = (req.opcode == OP_START);
    dec.is_take         = (req.opcode == OP_TAKE);
    dec.is_finish       = (req.opcode == OP_FINISH);
    dec.task_index      = req.task_index;
    dec.edge_slot       = req.edge_slot;
    dec.edge_target     = req.edge_target;
    dec.successor_count = req.successor_count;
    dec.main_only       = req.main_only;
    dec.start_dirty     = req.start_dirty;
    dec.start_pending   = req.start_pending;
    dec.from_main       = req.from_main;
  end

  assign req.ready = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rptr];
  assign push      = req.valid && req.ready;
  assign pop       = cmd_valid && cmd_ready;

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= dec;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[rtl/core/dtd_back.sv]
// back end: task tables, ready fifos and the command sequencer
`default_nettype none
module dtd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire dtd_pkg::cmd_t cmd,
  dtd_rsp_if.source          rsp
);
  import dtd_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_SC_RD   = 11'b00000000010,
    S_SC_PROC = 11'b00000000100,
    S_TK_WAIT = 11'b00000001000,
    S_FN_CNT  = 11'b00000010000,
    S_FN_N    = 11'b00000100000,
    S_FN_SRD  = 11'b00001000000,
    S_FN_WRD  = 11'b00010000000,
    S_FN_UPD  = 11'b00100000000,
    S_FN_END  = 11'b01000000000,
    S_RESP    = 11'b10000000000
  } state_t;

  state_t              state;
  state_t              state_next;
  cmd_t                cur;
  logic [TASK_W-1:0]   idx;
  logic [NSUCC_W-1:0]  nsucc;
  logic [NSUCC_W-1:0]  slot_i;
  logic [TASK_W-1:0]   succ_sel;
  logic                started;
  logic                tk_main;
  logic [TASK_W-1:0]   main_hd;
  logic [FCNT_W-1:0]   main_cnt;
  logic [TASK_W-1:0]   wk_hd;
  logic [FCNT_W-1:0]   wk_cnt;
  logic [FCNT_W-1:0]   ready_total;
  logic                res_status;
  logic                res_gvalid;
  logic [TASK_W-1:0]   res_gtask;

  // memory ports
  logic                task_we;
  logic [TASK_W-1:0]   task_waddr;
  task_entry_t         task_wdata;
  logic [TASK_W-1:0]   task_raddr;
  task_entry_t         task_rdata;
  logic                succ_we;
  logic [TASK_W-1:0]   succ_rdata;
  logic                dirty_we;
  logic [TASK_W-1:0]   dirty_waddr;
  logic                dirty_wdata;
  logic [TASK_W-1:0]   work_raddr;
  logic                dirty_rdata;
  logic                pend_we;
  logic [TASK_W-1:0]   pend_waddr;
  logic [PEND_W-1:0]   pend_wdata;
  logic [PEND_W-1:0]   pend_rdata;
  logic                main_we;
  logic                wk_we;
  logic [TASK_W-1:0]   push_val;
  logic [TASK_W-1:0]   fifo_rd_main;
  logic [TASK_W-1:0]   fifo_rd_wk;

  // push request towards a ready fifo
  logic                push_req;
  logic                push_main;
  logic                main_full;
  logic                wk_full;
  logic                push_ok;
  logic                cur_dirty;
  logic [PEND_W-1:0]   cur_pend;
  logic                take_main;
  logic                take_wk;
  logic                load_rsp;

  dtd_ram #(.WIDTH($bits(task_entry_t)), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk(clk), .we(task_we), .waddr(task_waddr), .wdata(task_wdata),
    .raddr(task_raddr), .rdata(task_rdata)
  );

  // edge writes take the command beat as it leaves the front queue
  dtd_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS * MAX_SUCCESSORS)) u_succ_ram (
    .clk(clk), .we(succ_we), .waddr({cmd.task_index, cmd.edge_slot}),
    .wdata(cmd.edge_target), .raddr({cur.task_index, slot_i[SLOT_W-1:0]}),
    .rdata(succ_rdata)
  );

  dtd_ram #(.WIDTH(1), .DEPTH(MAX_TASKS)) u_dirty_ram (
    .clk(clk), .we(dirty_we), .waddr(dirty_waddr), .wdata(dirty_wdata),
    .raddr(work_raddr), .rdata(dirty_rdata)
  );

  dtd_ram #(.WIDTH(PEND_W), .DEPTH(MAX_TASKS)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(work_raddr), .rdata(pend_rdata)
  );

  dtd_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_main_fifo (
    .clk(clk), .we(main_we), .waddr(TASK_W'(main_hd + main_cnt[TASK_W-1:0])),
    .wdata(push_val), .raddr(main_hd), .rdata(fifo_rd_main)
  );

  dtd_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_wk_fifo (
    .clk(clk), .we(wk_we), .waddr(TASK_W'(wk_hd + wk_cnt[TASK_W-1:0])),
    .wdata(push_val), .raddr(wk_hd), .rdata(fifo_rd_wk)
  );

  assign main_full = (main_cnt == FCNT_W'(MAX_TASKS));
  assign wk_full   = (wk_cnt == FCNT_W'(MAX_TASKS));
  assign cur_dirty = started && dirty_rdata;
  assign cur_pend  = started ? pend_rdata : '0;
  assign take_main = cmd.from_main && (main_cnt != '0);
  assign take_wk   = !take_main && (wk_cnt != '0);
  assign cmd_ready = (state == S_IDLE);
  assign load_rsp  = !rsp.valid || rsp.ready;

  // sequencer next state and memory controls
  always_comb begin
    state_next  = state;
    task_we     = 1'b0;
    task_waddr  = cur.task_index;
    task_wdata  = '0;
    task_raddr  = idx;
    succ_we     = 1'b0;
    dirty_we    = 1'b0;
    dirty_waddr = idx;
    dirty_wdata = 1'b0;
    pend_we     = 1'b0;
    pend_waddr  = idx;
    pend_wdata  = '0;
    work_raddr  = succ_rdata;
    push_req    = 1'b0;
    push_main   = 1'b0;
    push_val    = idx;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          priority if (cmd.is_load_task) state_next = S_RESP;
          else if (cmd.is_load_edge) state_next = S_RESP;
          else if (cmd.is_start) state_next = S_SC_RD;
          else if (cmd.is_take) begin
            state_next = (take_main || take_wk) ? S_TK_WAIT : S_RESP;
          end
          else if (cmd.is_finish) state_next = S_FN_CNT;
          else state_next = S_RESP;
        end
      end
      S_SC_RD: begin
        task_raddr = idx;
        state_next = S_SC_PROC;
      end
      S_SC_PROC: begin
        dirty_we    = 1'b1;
        dirty_waddr = idx;
        dirty_wdata = task_rdata.start_dirty;
        pend_we     = 1'b1;
        pend_waddr  = idx;
        pend_wdata  = task_rdata.start_pending;
        push_req    = task_rdata.start_dirty && (task_rdata.start_pending == '0);
        push_main   = task_rdata.main_only;
        push_val    = idx;
        state_next  = (idx == TASK_W'(MAX_TASKS - 1)) ? S_RESP : S_SC_RD;
      end
      S_TK_WAIT: begin
        dirty_we    = 1'b1;
        dirty_waddr = tk_main ? fifo_rd_main : fifo_rd_wk;
        dirty_wdata = 1'b0;
        state_next  = S_RESP;
      end
      S_FN_CNT: begin
        task_raddr = cur.task_index;
        state_next = S_FN_N;
      end
      S_FN_N: begin
        state_next = (task_rdata.succ_count == '0) ? S_FN_END : S_FN_SRD;
      end
      S_FN_SRD: begin
        state_next = S_FN_WRD;
      end
      S_FN_WRD: begin
        task_raddr = succ_rdata;
        work_raddr = succ_rdata;
        state_next = S_FN_UPD;
      end
      S_FN_UPD: begin
        if (cur_dirty && (cur_pend != '0)) begin
          pend_we    = 1'b1;
          pend_waddr = succ_sel;
          pend_wdata = cur_pend - PEND_W'(1);
          push_req   = (cur_pend == PEND_W'(1));
        end
        push_main  = task_rdata.main_only;
        push_val   = succ_sel;
        state_next = (NSUCC_W'(slot_i + NSUCC_W'(1)) == nsucc) ? S_FN_END : S_FN_SRD;
      end
      S_FN_END: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_IDLE && cmd_valid) begin
      if (cmd.is_load_task) begin
        task_we    = 1'b1;
        task_waddr = cmd.task_index;
        task_wdata.main_only     = cmd.main_only;
        task_wdata.start_dirty   = cmd.start_dirty;
        task_wdata.start_pending = cmd.start_pending;
        task_wdata.succ_count    = (cmd.successor_count > NSUCC_W'(MAX_SUCCESSORS)) ?
                                   NSUCC_W'(MAX_SUCCESSORS) : cmd.successor_count;
      end
      succ_we = cmd.is_load_edge;
    end
  end

  assign push_ok = push_req && (push_main ? !main_full : !wk_full);
  assign main_we = push_req && push_main && !main_full;
  assign wk_we   = push_req && !push_main && !wk_full;

  // sequencer registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      cur        <= cmd;
      tk_main    <= take_main;
      res_status <= cmd.is_take && !take_main && !take_wk;
      res_gvalid <= 1'b0;
      res_gtask  <= '0;
    end
    if (state == S_TK_WAIT) begin
      res_gvalid <= 1'b1;
      res_gtask  <= tk_main ? fifo_rd_main : fifo_rd_wk;
    end
    if (state == S_FN_N) begin
      nsucc  <= task_rdata.succ_count;
      slot_i <= '0;
    end
    if (state == S_FN_WRD) begin
      succ_sel <= succ_rdata;
    end
    if (state == S_FN_UPD) begin
      slot_i <= slot_i + NSUCC_W'(1);
    end
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      started     <= 1'b0;
      main_hd     <= '0;
      main_cnt    <= '0;
      wk_hd       <= '0;
      wk_cnt      <= '0;
      ready_total <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      // start of step: empty fifos, clear in-flight count
      if (state == S_IDLE && cmd_valid && cmd.is_start) begin
        idx         <= '0;
        main_hd     <= '0;
        main_cnt    <= '0;
        wk_hd       <= '0;
        wk_cnt      <= '0;
        ready_total <= '0;
      end else begin
        // pop on take
        if (state == S_IDLE && cmd_valid && cmd.is_take) begin
          if (take_main) begin
            main_hd  <= main_hd + TASK_W'(1);
            main_cnt <= main_cnt - FCNT_W'(1);
          end else if (take_wk) begin
            wk_hd  <= wk_hd + TASK_W'(1);
            wk_cnt <= wk_cnt - FCNT_W'(1);
          end
        end
        if (main_we) begin
          main_cnt <= main_cnt + FCNT_W'(1);
        end
        if (wk_we) begin
          wk_cnt <= wk_cnt + FCNT_W'(1);
        end
        if (push_ok) begin
          ready_total <= ready_total + FCNT_W'(1);
        end
        if (state == S_FN_END && ready_total != '0) begin
          ready_total <= ready_total - FCNT_W'(1);
        end
      end
      if (state == S_SC_PROC) begin
        idx     <= idx + TASK_W'(1);
        started <= 1'b1;
      end
      // result register
      if (state == S_RESP && load_rsp) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_RESP && load_rsp) begin
      rsp.status        <= res_status;
      rsp.granted_valid <= res_gvalid;
      rsp.granted_task  <= res_gtask;
      rsp.in_flight     <= ready_total;
      rsp.all_done      <= (ready_total == '0);
    end
  end
endmodule
`default_nettype wire

[dv/dataflow_task_dispatcher_checker.sv]
// scoreboard for the task dispatcher: predicts every response beat and compares it
module dataflow_task_dispatcher_checker (
  input  wire logic clk,
  input  wire logic rst,
  dtd_req_if        req,
  dtd_rsp_if        rsp,
  output int        fail_count,
  output int        outstanding
);
  import dtd_pkg::*;

  typedef struct packed {
    logic             status;
    logic             granted_valid;
    logic [TASK_W-1:0] granted_task;
    logic [6:0]       in_flight;
    logic             all_done;
  } dispatch_result_t;

  // shadow of the static task and edge tables
  logic               sh_main_only   [MAX_TASKS];
  logic               sh_start_dirty [MAX_TASKS];
  logic [PEND_W-1:0]  sh_start_pend  [MAX_TASKS];
  int                 sh_succ_count  [MAX_TASKS];
  logic [TASK_W-1:0]  sh_succ        [MAX_TASKS*MAX_SUCCESSORS];

  // shadow of the working state
  logic               work_dirty [MAX_TASKS];
  logic [PEND_W-1:0]  work_pend  [MAX_TASKS];
  logic [TASK_W-1:0]  main_ready_q[$];
  logic [TASK_W-1:0]  worker_ready_q[$];
  int                 tasks_in_flight;

  dispatch_result_t   expected_rsp_q[$];

  // queue a task that has become runnable
  function automatic void enqueue_runnable(input int t);
    if (sh_main_only[t]) begin
      if (main_ready_q.size() < MAX_TASKS) begin
        main_ready_q.insert(main_ready_q.size(), TASK_W'(t));
        tasks_in_flight++;
      end
    end else begin
      if (worker_ready_q.size() < MAX_TASKS) begin
        worker_ready_q.insert(worker_ready_q.size(), TASK_W'(t));
        tasks_in_flight++;
      end
    end
  endfunction

  // apply one request beat and work out its response
  function automatic dispatch_result_t dispatch_step(
    input logic [2:0] op, input logic [TASK_W-1:0] idx, input logic [SLOT_W-1:0] slot,
    input logic [TASK_W-1:0] tgt, input logic [NSUCC_W-1:0] nsucc, input logic mo,
    input logic sd, input logic [PEND_W-1:0] sp, input logic fm);
    dispatch_result_t r;
    int n;
    int s;
    logic [TASK_W-1:0] v;
    r = '0;
    case (op)
      OP_LOAD_TASK: begin
        sh_main_only[idx]   = mo;
        sh_start_dirty[idx] = sd;
        sh_start_pend[idx]  = sp;
        sh_succ_count[idx]  = (nsucc > MAX_SUCCESSORS) ? MAX_SUCCESSORS : int'(nsucc);
      end
      OP_LOAD_EDGE: begin
        sh_succ[int'(idx)*MAX_SUCCESSORS + int'(slot)] = tgt;
      end
      OP_START: begin
        main_ready_q.delete();
        worker_ready_q.delete();
        tasks_in_flight = 0;
        for (int i = 0; i < MAX_TASKS; i++) begin
          work_dirty[i] = sh_start_dirty[i];
          work_pend[i]  = sh_start_pend[i];
        end
        for (int i = 0; i < MAX_TASKS; i++)
          if (work_dirty[i] && work_pend[i] == 0) enqueue_runnable(i);
      end
      OP_TAKE: begin
        if (fm && main_ready_q.size() > 0) begin
          v = main_ready_q[0];
          main_ready_q.delete(0);
          r.granted_valid = 1'b1;
        end else if (worker_ready_q.size() > 0) begin
          v = worker_ready_q[0];
          worker_ready_q.delete(0);
          r.granted_valid = 1'b1;
        end
        if (r.granted_valid) begin
          work_dirty[v] = 1'b0;
          r.granted_task = v;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_FINISH: begin
        n = sh_succ_count[idx];
        for (int i = 0; i < n; i++) begin
          s = sh_succ[int'(idx)*MAX_SUCCESSORS + i];
          if (work_dirty[s] && work_pend[s] > 0) begin
            work_pend[s] = work_pend[s] - 1'b1;
            if (work_pend[s] == 0) enqueue_runnable(s);
          end
        end
        if (tasks_in_flight > 0) tasks_in_flight--;
      end
      default: begin
      end
    endcase
    r.in_flight = 7'(tasks_in_flight);
    r.all_done  = (tasks_in_flight == 0);
    return r;
  endfunction

  initial begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      sh_main_only[i] = 1'b0;
      sh_start_dirty[i] = 1'b0;
      sh_start_pend[i] = '0;
      sh_succ_count[i] = 0;
      work_dirty[i] = 1'b0;
      work_pend[i] = '0;
    end
    for (int i = 0; i < MAX_TASKS*MAX_SUCCESSORS; i++) sh_succ[i] = '0;
    tasks_in_flight = 0;
  end

  // predict on request beats, compare on response beats
  always @(posedge clk) begin
    dispatch_result_t got;
    dispatch_result_t want;
    if (rst) begin
      fail_count = 0;
      outstanding = 0;
    end else begin
      if (req.valid && req.ready)
        expected_rsp_q.insert(expected_rsp_q.size(), dispatch_step(req.opcode,
          req.task_index, req.edge_slot, req.edge_target, req.successor_count,
          req.main_only, req.start_dirty, req.start_pending, req.from_main));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.granted_valid, rsp.granted_task, rsp.in_flight,
                rsp.all_done};
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: response beat with nothing expected, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_rsp_q[0];
          expected_rsp_q.delete(0);
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          if (got.granted_valid !== want.granted_valid)
            $display("%0t: granted_valid expected %0d actual %0d", $time,
                     want.granted_valid, got.granted_valid);
          if (got.granted_task !== want.granted_task)
            $display("%0t: granted_task expected %0d actual %0d", $time,
                     want.granted_task, got.granted_task);
          if (got.in_flight !== want.in_flight)
            $display("%0t: in_flight expected %0d actual %0d", $time,
                     want.in_flight, got.in_flight);
          if (got.all_done !== want.all_done)
            $display("%0t: all_done expected %0d actual %0d", $time,
                     want.all_done, got.all_done);
          if (got !== want) fail_count++;
        end
      end
      outstanding = expected_rsp_q.size();
    end
  end

endmodule

[dv/dataflow_task_dispatcher_tb.sv]
// top of the task dispatcher testbench: clock, reset, stimulus and verdict
module dataflow_task_dispatcher_tb;
  import dtd_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int ITEM_BUDGET = 850;

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   sent_count;
  int   rsp_count;
  int   stall_cycles;
  int   fail_count;
  int   outstanding;
  int   grants_seen;
  logic last_granted;
  logic [TASK_W-1:0] last_grant_task;

  dtd_req_if req ();
  dtd_rsp_if rsp ();

  dataflow_task_dispatcher dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  dataflow_task_dispatcher_checker u_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // response tracking for the stimulus side, and the stall counter
  always @(posedge clk) begin
    if (rst) begin
      rsp_count <= 0;
      stall_cycles <= 0;
      last_granted <= 1'b0;
      grants_seen <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp_count <= rsp_count + 1;
        last_granted <= rsp.granted_valid;
        last_grant_task <= rsp.granted_task;
        if (rsp.granted_valid) grants_seen <= grants_seen + 1;
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // watchdog
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall_cycles >= STALL_LIMIT) begin
        $display("dataflow_task_dispatcher verification failed");
        $finish;
      end
    end
  end

  // one request beat with random idling in front of it
  task automatic send_beat(input logic [2:0] op, input logic [TASK_W-1:0] idx,
                           input logic [SLOT_W-1:0] slot, input logic [TASK_W-1:0] tgt,
                           input logic [NSUCC_W-1:0] nsucc, input logic mo, input logic sd,
                           input logic [PEND_W-1:0] sp, input logic fm);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.task_index <= idx;
    req.edge_slot <= slot;
    req.edge_target <= tgt;
    req.successor_count <= nsucc;
    req.main_only <= mo;
    req.start_dirty <= sd;
    req.start_pending <= sp;
    req.from_main <= fm;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic load_task(input logic [TASK_W-1:0] idx, input logic mo, input logic sd,
                           input logic [PEND_W-1:0] sp, input logic [NSUCC_W-1:0] nsucc);
    send_beat(OP_LOAD_TASK, idx, 3'($urandom), 6'($urandom), nsucc, mo, sd, sp, 1'($urandom));
  endtask

  task automatic load_edge(input logic [TASK_W-1:0] idx, input logic [SLOT_W-1:0] slot,
                           input logic [TASK_W-1:0] tgt);
    send_beat(OP_LOAD_EDGE, idx, slot, tgt, 4'($urandom), 1'($urandom), 1'($urandom),
              9'($urandom), 1'($urandom));
  endtask

  task automatic simple_op(input logic [2:0] op, input logic [TASK_W-1:0] idx,
                           input logic fm);
    send_beat(op, idx, 3'($urandom), 6'($urandom), 4'($urandom), 1'($urandom),
              1'($urandom), 9'($urandom), fm);
  endtask

  // wait until every request beat has been answered
  task automatic wait_responses();
    req.valid <= 1'b0;
    @(posedge clk);
    while (rsp_count != sent_count) @(posedge clk);
  endtask

  // pending count biased towards short dependency chains
  function automatic logic [PEND_W-1:0] pick_pending();
    int r;
    r = $urandom_range(99);
    if (r < 55) return '0;
    if (r < 90) return PEND_W'($urandom_range(1, 3));
    return PEND_W'($urandom);
  endfunction

  task automatic random_load_task();
    load_task(6'($urandom), ($urandom_range(99) < 30), ($urandom_range(99) < 80),
              pick_pending(), 4'($urandom));
  endtask

  // a step: a few table edits, a start, then take, finish, unknown-opcode and table-edit traffic
  task automatic run_step(input int stop_at);
    int r;
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(1)) random_load_task();
      else load_edge(6'($urandom), 3'($urandom), 6'($urandom));
    end
    simple_op(OP_START, 6'($urandom), 1'($urandom));
    repeat ($urandom_range(5, 40)) begin
      if (sent_count >= stop_at) break;
      r = $urandom_range(99);
      if (r < 60) begin
        simple_op(OP_TAKE, 6'($urandom), 1'($urandom));
        wait_responses();
        if (last_granted && $urandom_range(99) < 90)
          simple_op(OP_FINISH, last_grant_task, 1'($urandom));
      end else if (r < 72) begin
        simple_op(OP_FINISH, 6'($urandom), 1'($urandom));
      end else if (r < 84) begin
        simple_op(OP_TAKE, 6'($urandom), 1'($urandom));
      end else if (r < 92) begin
        simple_op(3'(OP_FINISH) + 3'($urandom_range(1, 3)), 6'($urandom), 1'($urandom));
      end else if (r < 96) begin
        random_load_task();
      end else begin
        load_edge(6'($urandom), 3'($urandom), 6'($urandom));
      end
    end
  endtask

  initial begin
    int stop_at;
    int base;
    rst = 1'b1;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    sent_count = 0;
    req.valid = 1'b0;
    req.opcode = OP_LOAD_TASK;
    req.task_index = '0;
    req.edge_slot = '0;
    req.edge_target = '0;
    req.successor_count = '0;
    req.main_only = 1'b0;
    req.start_dirty = 1'b0;
    req.start_pending = '0;
    req.from_main = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // take with both fifos empty straight out of reset
    simple_op(OP_TAKE, '0, 1'b1);
    simple_op(OP_TAKE, '0, 1'b0);

    // fill the whole edge table, then load MAX_TASKS task entries at random indices
    for (int t = 0; t < MAX_TASKS; t++)
      for (int s = 0; s < MAX_SUCCESSORS; s++)
        load_edge(TASK_W'(t), SLOT_W'(s), 6'($urandom));
    for (int t = 0; t < MAX_TASKS; t++) random_load_task();

    // directed corners
    simple_op(OP_FINISH, '0, 1'b0);
    for (int u = 1; u <= 3; u++) simple_op(3'(OP_FINISH) + 3'(u), 6'h3f, 1'b1);
    load_task(6'd5, 1'b1, 1'b1, 9'd0, 4'd15);
    load_edge(6'd5, 3'd0, 6'd6);
    load_edge(6'd5, 3'd1, 6'd6);
    load_edge(6'd5, 3'd7, 6'd63);
    load_task(6'd6, 1'b0, 1'b1, 9'd2, 4'd0);
    load_task(6'd7, 1'b1, 1'b1, 9'h1ff, 4'd0);
    load_task(6'd63, 1'b0, 1'b1, 9'd0, 4'd8);
    load_task(6'd0, 1'b0, 1'b0, 9'd0, 4'd0);
    simple_op(OP_START, '0, 1'b0);
    simple_op(OP_TAKE, '0, 1'b0);
    simple_op(OP_TAKE, '0, 1'b1);
    simple_op(OP_FINISH, 6'd5, 1'b0);
    simple_op(OP_FINISH, 6'd5, 1'b0);
    simple_op(OP_TAKE, '0, 1'b1);
    repeat (3) simple_op(OP_TAKE, '0, 1'b0);
    wait_responses();

    // random traffic in three idling regimes, sharing what is left of the budget
    base = sent_count;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 34; rx_idle_pct = 79; end
        1: begin tx_idle_pct = 79; rx_idle_pct = 34; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      stop_at = base + (ph + 1) * (ITEM_BUDGET - base) / 3;
      while (sent_count < stop_at) run_step(stop_at);
    end

    // drain
    wait_responses();
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d request beats and %0d grants over three idling regimes",
             sent_count, grants_seen);
    $display("table fill, empty takes, saturated counts, unknown opcodes and idle finishes");
    if (fail_count == 0) begin
      $display("dataflow_task_dispatcher verification clean");
    end else begin
      $display("dataflow_task_dispatcher verification failed");
    end
    $finish;
  end

endmodule
